/* src/sin_cos_taylor_octant_defines.svh */
// ----------------------------------------------------------------------------
// sin_cos_taylor_octant_defines.svh
// Assertion macros shared by the sine/cosine checker.
// The macros expect signals named aclk and aresetn in the scope of use.
// ----------------------------------------------------------------------------
`ifndef SIN_COS_TAYLOR_OCTANT_DEFINES_SVH
`define SIN_COS_TAYLOR_OCTANT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SCT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SCT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must hold in the cycle after a reset edge.
`define SCT_ASSERT_RST(label, cons, msg) \
    label: assert property (@(posedge aclk) (!aresetn) |=> (cons)) \
        else $error(msg);

`endif

/* src/sct_pkg.sv */
// ----------------------------------------------------------------------------
// sct_pkg
// Types, constants and arithmetic helpers of the sine/cosine pipeline.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int ANGLE_W         = 32;
    localparam int VALUE_W         = 32;
    localparam int ANGLE_FRAC_BITS = 29;
    localparam int OUT_FRAC_BITS   = 30;
    localparam int TERMS_DEFAULT   = 13;
    localparam int FACT_CAP        = 20;

    // Kernel magnitudes are Q0.62, terms and coefficients hold 1.0 as well.
    localparam int KW  = 62;
    localparam int TW  = 63;
    localparam int ACW = 64;

    localparam logic [63:0] ONE_Q62 = 64'd1 << 62;
    localparam logic [63:0] PI4_Q61 = 64'h1921FB54442D1847;

    localparam logic signed [VALUE_W-1:0] VALUE_ONE = VALUE_W'(64'd1 << OUT_FRAC_BITS);

    typedef enum logic {
        OP_SIN = 1'b0,
        OP_COS = 1'b1
    } op_t;

    typedef struct packed {
        logic want_cos;
        logic xneg;
        logic out_neg;
    } kflags_t;

    typedef struct packed {
        logic [61:0] p00;
        logic [62:0] p01;
        logic [61:0] p10;
        logic [62:0] p11;
    } mulpp_t;

    // m quarters of pi (eighths of a turn) in angle format, rounded half up.
    function automatic logic [63:0] eighth_offset(input int unsigned m);
        logic [63:0] v;
        int unsigned s;
        v = 64'(m) * PI4_Q61;
        s = 61 - ANGLE_FRAC_BITS;
        if (s == 0) begin
            return v;
        end
        return (v + (64'd1 << (s - 1))) >> s;
    endfunction

    function automatic logic [63:0] fact_of(input int unsigned p);
        logic [63:0] f;
        int unsigned i;
        f = 64'd1;
        for (i = 2; i <= FACT_CAP; i++) begin
            if (i <= p) begin
                f = f * 64'(i);
            end
        end
        return f;
    endfunction

    // Four 31/32-bit partial products of a Q0.62 magnitude and a Q1.62 factor.
    function automatic mulpp_t mul_split(input logic [KW-1:0] a, input logic [TW-1:0] b);
        mulpp_t pp;
        pp.p00 = 62'(a[30:0]) * 62'(b[30:0]);
        pp.p01 = 63'(a[30:0]) * 63'(b[62:31]);
        pp.p10 = 62'(a[61:31]) * 62'(b[30:0]);
        pp.p11 = 63'(a[61:31]) * 63'(b[62:31]);
        return pp;
    endfunction

    // Sum of the partial products, rounded half up and scaled back to Q1.62.
    function automatic logic [TW-1:0] mul_round(input mulpp_t pp);
        logic [126:0] s;
        s = (127'(pp.p11) << 62) + (127'(pp.p01) << 31) + (127'(pp.p10) << 31)
            + 127'(pp.p00) + (127'(1) << 61);
        return s[124:62];
    endfunction

    // Adds the term of power p, if the wanted series uses that power, with the
    // series sign, the argument sign and the quadrant sign applied.
    function automatic logic signed [ACW-1:0] acc_add(input logic signed [ACW-1:0] acc,
                                                      input logic [TW-1:0] term,
                                                      input int unsigned p,
                                                      input kflags_t f);
        logic [1:0] r;
        logic use_t;
        logic base_neg;
        logic neg_t;
        logic signed [ACW-1:0] t;
        r        = 2'(p);
        t        = $signed(ACW'(term));
        use_t    = f.want_cos ? !r[0] : r[0];
        base_neg = f.want_cos ? (r == 2'd2) : (r == 2'd3);
        neg_t    = base_neg ^ f.out_neg ^ (f.xneg & r[0]);
        if (!use_t) begin
            return acc;
        end
        return neg_t ? acc - t : acc + t;
    endfunction

endpackage

/* src/sin_cos_taylor_octant.sv */
// ----------------------------------------------------------------------------
// sin_cos_taylor_octant
// Pipelined fixed-point sine/cosine with octant reduction and a Taylor kernel.
//
// Channel  Dir  Handshake           Payload
// s_       in   s_valid / s_ready   s_op (0 sine, 1 cosine), s_angle (Q3.29)
// m_       out  m_valid / m_ready   m_value (signed Q2.30)
//
// One transfer per cycle in each direction when the output is not stalled.
// The pipeline has two reduction stages, two stages per series power
// (partial products, then sum), two output stages and the output register.
// Reset clears only the valid flags; there is no clearing pass.
// A one-entry skid register behind the output register catches the item in
// flight; s_ready is the registered inverse of the skid being full.
// ----------------------------------------------------------------------------
module sin_cos_taylor_octant #(
    parameter int unsigned TERMS = sct_pkg::TERMS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  sct_pkg::op_t                        s_op,
    input  logic [sct_pkg::ANGLE_W-1:0]         s_angle,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [sct_pkg::VALUE_W-1:0]  m_value
);
    import sct_pkg::*;

    localparam logic [63:0] Q64 = eighth_offset(1);
    localparam logic [63:0] TH1 = Q64;
    localparam logic [63:0] TH3 = 64'd3 * Q64;
    localparam logic [63:0] TH5 = 64'd5 * Q64;
    localparam logic [63:0] TH7 = 64'd7 * Q64;

    localparam logic [ANGLE_W-1:0] Q_ANG = ANGLE_W'(Q64);
    localparam logic [ANGLE_W-1:0] OFF0  = ANGLE_W'(eighth_offset(0));
    localparam logic [ANGLE_W-1:0] OFF2  = ANGLE_W'(eighth_offset(2));
    localparam logic [ANGLE_W-1:0] OFF4  = ANGLE_W'(eighth_offset(4));
    localparam logic [ANGLE_W-1:0] OFF6  = ANGLE_W'(eighth_offset(6));
    localparam logic [ANGLE_W-1:0] OFF8  = ANGLE_W'(eighth_offset(8));

    localparam int XSHIFT    = 62 - ANGLE_FRAC_BITS;
    localparam int OUT_SHIFT = 62 - OUT_FRAC_BITS;
    localparam int UW        = ACW - OUT_SHIFT;

    localparam logic [ACW-1:0] ROUND_HALF = 64'd1 << (OUT_SHIFT - 1);
    localparam logic [UW-1:0]  U_LIMIT    = UW'(64'd1 << OUT_FRAC_BITS);

    logic en;

    // Stage 1: octant compare, offset and sign selection.
    logic               ge1, ge3, ge5, ge7, odd_seg;
    logic [ANGLE_W-1:0] off1_next;
    logic               wcos1_next, oneg1_next;
    logic               v1_reg;
    logic [ANGLE_W-1:0] angle1_reg, off1_reg;
    logic               wcos1_reg, oneg1_reg;

    // Stage 2: shifted argument.
    logic               a_ge_off;
    logic [ANGLE_W-1:0] up_diff, dn_diff, mag, mag_sat;
    logic [KW-1:0]      x2_next;
    kflags_t            fl2_next;
    logic               v2_reg;
    logic [KW-1:0]      x2_reg;
    kflags_t            fl2_reg;

    // Links between series steps; index J is the output of step J.
    logic                  step_v    [0:TERMS];
    kflags_t               step_fl   [0:TERMS];
    logic signed [ACW-1:0] step_acc  [0:TERMS];
    logic [TW-1:0]         step_term [0:TERMS];
    logic [KW-1:0]         step_x    [0:TERMS-2];
    logic [KW-1:0]         step_pw   [0:TERMS-1];

    // Output conversion.
    logic signed [ACW-1:0] accf_next;
    logic                  vf1_reg;
    logic signed [ACW-1:0] accf_reg;
    logic [ACW-1:0]        acc_u, rsum;
    logic                  vf2_reg, negf2_reg;
    logic [UW-1:0]         u2_reg, usat;
    logic [VALUE_W-1:0]    mag_out;
    logic signed [VALUE_W-1:0] last_value;

    logic                      m_valid_reg, skid_valid_reg;
    logic signed [VALUE_W-1:0] m_value_reg, skid_value_reg;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    always_comb begin
        ge1        = 64'(s_angle) >= TH1;
        ge3        = 64'(s_angle) >= TH3;
        ge5        = 64'(s_angle) >= TH5;
        ge7        = 64'(s_angle) >= TH7;
        odd_seg    = (ge1 && !ge3) || (ge5 && !ge7);
        wcos1_next = odd_seg ^ (s_op == OP_COS);
        oneg1_next = (s_op == OP_SIN) ? (ge3 && !ge7) : (ge1 && !ge5);
        if (ge7) begin
            off1_next = OFF8;
        end else if (ge5) begin
            off1_next = OFF6;
        end else if (ge3) begin
            off1_next = OFF4;
        end else if (ge1) begin
            off1_next = OFF2;
        end else begin
            off1_next = OFF0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            angle1_reg <= s_angle;
            off1_reg   <= off1_next;
            wcos1_reg  <= wcos1_next;
            oneg1_reg  <= oneg1_next;
        end
    end

    always_comb begin
        a_ge_off          = angle1_reg >= off1_reg;
        up_diff           = angle1_reg - off1_reg;
        dn_diff           = off1_reg - angle1_reg;
        mag               = a_ge_off ? up_diff : dn_diff;
        mag_sat           = (mag > Q_ANG) ? Q_ANG : mag;
        x2_next           = KW'(64'(mag_sat) << XSHIFT);
        fl2_next.want_cos = wcos1_reg;
        fl2_next.xneg     = !a_ge_off;
        fl2_next.out_neg  = oneg1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x2_reg  <= x2_next;
            fl2_reg <= fl2_next;
        end
    end

    // Power zero: the term is 1.0 and the accumulator starts empty.
    assign step_v[0]    = v2_reg;
    assign step_fl[0]   = fl2_reg;
    assign step_acc[0]  = '0;
    assign step_term[0] = TW'(ONE_Q62);
    assign step_x[0]    = x2_reg;
    assign step_pw[0]   = x2_reg;

    for (genvar J = 1; J <= TERMS; J++) begin : g_step
        localparam logic [63:0] FACT_J  = fact_of(J);
        localparam logic [63:0] RECIP64 = (J <= FACT_CAP) ?
                                          (ONE_Q62 + FACT_J / 64'd2) / FACT_J : 64'd0;
        localparam logic [TW-1:0] RECIP_J = TW'(RECIP64);

        logic signed [ACW-1:0] acca_next;
        logic                  va_reg, vb_reg;
        kflags_t               fla_reg, flb_reg;
        logic signed [ACW-1:0] acca_reg, accb_reg;
        mulpp_t                ppt_reg;
        logic [TW-1:0]         termb_reg;

        assign acca_next = acc_add(step_acc[J-1], step_term[J-1], J - 1, step_fl[J-1]);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                va_reg <= 1'b0;
                vb_reg <= 1'b0;
            end else if (en) begin
                va_reg <= step_v[J-1];
                vb_reg <= va_reg;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                fla_reg   <= step_fl[J-1];
                acca_reg  <= acca_next;
                ppt_reg   <= mul_split(step_pw[J-1], RECIP_J);
                flb_reg   <= fla_reg;
                accb_reg  <= acca_reg;
                termb_reg <= mul_round(ppt_reg);
            end
        end

        assign step_v[J]    = vb_reg;
        assign step_fl[J]   = flb_reg;
        assign step_acc[J]  = accb_reg;
        assign step_term[J] = termb_reg;

        if (J < TERMS) begin : g_pw
            logic [KW-1:0] pwb_reg;
            mulpp_t        ppw_reg;

            always_ff @(posedge aclk) begin
                if (en) begin
                    ppw_reg <= mul_split(step_pw[J-1], TW'(step_x[J-1]));
                    pwb_reg <= KW'(mul_round(ppw_reg));
                end
            end

            assign step_pw[J] = pwb_reg;

            if (J < TERMS - 1) begin : g_x
                logic [KW-1:0] xa_reg, xb_reg;

                always_ff @(posedge aclk) begin
                    if (en) begin
                        xa_reg <= step_x[J-1];
                        xb_reg <= xa_reg;
                    end
                end

                assign step_x[J] = xb_reg;
            end
        end
    end

    assign accf_next = acc_add(step_acc[TERMS], step_term[TERMS], TERMS, step_fl[TERMS]);

    always_comb begin
        acc_u = accf_reg;
        if (accf_reg[ACW-1]) begin
            rsum = ~acc_u + (ROUND_HALF + 64'd1);
        end else begin
            rsum = acc_u + ROUND_HALF;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vf1_reg <= 1'b0;
            vf2_reg <= 1'b0;
        end else if (en) begin
            vf1_reg <= step_v[TERMS];
            vf2_reg <= vf1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            accf_reg  <= accf_next;
            negf2_reg <= accf_reg[ACW-1];
            u2_reg    <= rsum[ACW-1:OUT_SHIFT];
        end
    end

    always_comb begin
        usat       = (u2_reg > U_LIMIT) ? U_LIMIT : u2_reg;
        mag_out    = VALUE_W'(usat);
        last_value = negf2_reg ? $signed(-mag_out) : $signed(mag_out);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= vf2_reg;
            end
        end else if (vf2_reg && en) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            m_value_reg <= skid_valid_reg ? skid_value_reg : last_value;
        end else if (en) begin
            skid_value_reg <= last_value;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;

endmodule

/* src/sct_checker.sv */
// ----------------------------------------------------------------------------
// sct_checker
// Port-level checks of the sine/cosine pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`include "sin_cos_taylor_octant_defines.svh"

module sct_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [sct_pkg::VALUE_W-1:0]  m_value
);
    import sct_pkg::*;

    // Items taken in and not yet delivered.
    logic [15:0] outstanding_reg, outstanding_next;

    assign outstanding_next = outstanding_reg + 16'(s_valid && s_ready)
                              - 16'(m_valid && m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outstanding_reg <= '0;
        end else begin
            outstanding_reg <= outstanding_next;
        end
    end

    `SCT_ASSERT_IMP(a_value_range, m_valid, (m_value <= VALUE_ONE) && (m_value >= -VALUE_ONE), "result outside plus or minus one")
    `SCT_ASSERT_IMP(a_no_orphan, m_valid, outstanding_reg != 16'd0, "result without a matching input")
    `SCT_ASSERT_IMP(a_ready_drop, !s_ready, m_valid, "input stalled while output is empty")
    `SCT_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_value), "stalled result changed")
    `SCT_ASSERT_RST(a_reset_idle, !m_valid, "result valid after reset")

endmodule

bind sin_cos_taylor_octant sct_checker u_sct_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_value (m_value)
);

/* test/sin_cos_taylor_octant_tb.sv */
// ----------------------------------------------------------------------------
// sin_cos_taylor_octant_tb
// Self-checking testbench for the pipelined sine/cosine block.
//
// A bit-exact fixed-point model of the octant reduction and the Taylor series
// predicts every accepted input transfer. A checker compares each output
// transfer with the oldest prediction. Directed angles hit zero, two pi, the
// top of the angle range and both sides of every octant edge. Random angles
// cover the full input range, the base period and the octant edges. Random
// gaps on both channels are followed by a back-to-back phase.
// ----------------------------------------------------------------------------
module sin_cos_taylor_octant_tb;

    import sct_pkg::*;

    localparam int unsigned SERIES_TERMS = 13;
    localparam int unsigned LATENCY      = 2 * SERIES_TERMS + 5;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam logic [63:0] Q62_ONE      = 64'd1 << 62;
    localparam logic [63:0] PI_QUARTER   = 64'h1921FB54442D1847;
    localparam logic [31:0] TWO_PI_ANGLE = 32'd3373259426;

    typedef struct {
        op_t                op;
        logic [31:0]        angle;
        logic signed [31:0] value;
    } value_exp_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    op_t                s_op;
    logic [31:0]        s_angle;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_value;

    value_exp_t  value_q[$];
    int unsigned err_count;
    int unsigned sent_count;
    int unsigned sin_count;
    int unsigned cos_count;
    int unsigned past_count;
    int unsigned checked_count;
    int unsigned cycle_count;
    int unsigned ready_hold;
    logic        back_to_back;
    logic [63:0] eighth;

    sin_cos_taylor_octant #(
        .TERMS(SERIES_TERMS)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .s_angle (s_angle),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_value (m_value)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    function automatic logic [63:0] qmul62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = 128'(a) * 128'(b) + (128'(1) << 61);
        return prod[125:62];
    endfunction

    function automatic logic [63:0] angle_eighth(input int unsigned m);
        logic [63:0] v;
        v = 64'(m) * PI_QUARTER;
        return (v + (64'd1 << 31)) >> 32;
    endfunction

    function automatic logic signed [63:0] series_sum(input logic [63:0] xmag,
                                                      input logic xneg,
                                                      input logic want_cos);
        logic signed [63:0] acc;
        logic [63:0]        pw;
        logic [63:0]        fact;
        logic [63:0]        recip;
        logic [63:0]        term;
        logic [1:0]         r;
        int                 sgn;
        acc  = want_cos ? $signed(Q62_ONE) : 64'sd0;
        pw   = Q62_ONE;
        fact = 64'd1;
        for (int unsigned p = 1; p <= SERIES_TERMS; p++) begin
            recip = 64'd0;
            r     = p[1:0];
            sgn   = 0;
            pw    = qmul62(pw, xmag);
            if (p <= 20) begin
                fact  = fact * 64'(p);
                recip = (Q62_ONE + fact / 2) / fact;
            end
            term = qmul62(pw, recip);
            if (want_cos) begin
                if (r == 2'd2) sgn = -1;
                else if (r == 2'd0) sgn = 1;
            end else begin
                if (r == 2'd1) sgn = 1;
                else if (r == 2'd3) sgn = -1;
            end
            if (xneg && p[0]) sgn = -sgn;
            if (sgn > 0) acc = acc + $signed(term);
            else if (sgn < 0) acc = acc - $signed(term);
        end
        return acc;
    endfunction

    function automatic logic signed [31:0] predict_value(input op_t op,
                                                         input logic [31:0] ang);
        logic [63:0]        q;
        logic [63:0]        k;
        logic [63:0]        off;
        logic [63:0]        mag;
        logic [63:0]        u;
        int unsigned        seg;
        logic               xneg;
        logic               want_cos;
        logic               out_neg;
        logic               neg;
        logic signed [63:0] acc;
        q   = angle_eighth(1);
        k   = 64'(ang) / q;
        seg = (k >= 7) ? 4 : int'((k + 1) / 2);
        off = angle_eighth(2 * seg);
        if (64'(ang) >= off) begin
            mag  = 64'(ang) - off;
            xneg = 1'b0;
        end else begin
            mag  = off - 64'(ang);
            xneg = 1'b1;
        end
        if (mag > q) mag = q;
        want_cos = seg[0] ^ (op == OP_COS);
        if (op == OP_SIN) out_neg = (seg == 2 || seg == 3);
        else out_neg = (seg == 1 || seg == 2);
        acc = series_sum(mag << 33, xneg, want_cos);
        if (out_neg) acc = -acc;
        neg = acc < 0;
        u   = neg ? 64'd0 - 64'(acc) : 64'(acc);
        u   = (u + (64'd1 << 31)) >> 32;
        if (u > (64'd1 << 30)) u = 64'd1 << 30;
        if (neg) u = 64'd0 - u;
        return $signed(u[31:0]);
    endfunction

    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    task automatic report_mismatch(input string what);
        if (err_count < 40) begin
            $display("MISMATCH @%0d: %s", cycle_count, what);
        end
        err_count++;
    endtask

    task automatic send_angle(input op_t op, input logic [31:0] ang);
        int unsigned gap;
        gap = back_to_back ? 0 : pick_len();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_angle <= ang;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
        if (op == OP_SIN) sin_count++;
        else cos_count++;
        if (ang > TWO_PI_ANGLE) past_count++;
    endtask

    function automatic op_t rand_op();
        return op_t'($urandom_range(0, 1));
    endfunction

    task automatic test_directed();
        send_angle(OP_SIN, 32'd0);
        send_angle(OP_COS, 32'd0);
        for (int unsigned m = 1; m <= 8; m++) begin
            send_angle(op_t'(m[0]), 32'(m * eighth - 1));
            send_angle(op_t'(!m[0]), 32'(m * eighth));
        end
        send_angle(OP_SIN, TWO_PI_ANGLE);
        send_angle(OP_COS, TWO_PI_ANGLE);
        send_angle(OP_SIN, 32'hFFFF_FFFF);
        send_angle(OP_COS, 32'hFFFF_FFFF);
        send_angle(OP_COS, 32'h8000_0000);
        send_angle(OP_SIN, 32'h7FFF_FFFF);
    endtask

    task automatic test_full_range();
        repeat (200) send_angle(rand_op(), $urandom());
    endtask

    task automatic test_base_period();
        repeat (400) send_angle(rand_op(), $urandom_range(0, TWO_PI_ANGLE));
    endtask

    task automatic test_octant_edges();
        logic [63:0] base;
        repeat (230) begin
            base = 64'($urandom_range(1, 8)) * eighth;
            send_angle(rand_op(), 32'(base + 64'($urandom_range(0, 16)) - 64'd8));
        end
    endtask

    task automatic test_back_to_back();
        back_to_back = 1'b1;
        repeat (200) send_angle(rand_op(), $urandom_range(0, TWO_PI_ANGLE));
        back_to_back = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (back_to_back) begin
            m_ready <= 1'b1;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            m_ready    <= ($urandom_range(0, 9) < 7);
            ready_hold <= pick_len();
        end
    end

    always @(posedge aclk) begin : value_check
        value_exp_t e;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                e.op    = s_op;
                e.angle = s_angle;
                e.value = predict_value(s_op, s_angle);
                value_q.push_back(e);
            end
            if (m_valid && m_ready) begin
                if (value_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value=%0d", m_value));
                end else begin
                    e = value_q.pop_front();
                    checked_count++;
                    if (m_value !== e.value) begin
                        report_mismatch($sformatf("op=%s angle=0x%08h value=%0d expected=%0d",
                                                  e.op.name(), e.angle, m_value, e.value));
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results pending",
                     cycle_count, value_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        err_count     = 0;
        sent_count    = 0;
        sin_count     = 0;
        cos_count     = 0;
        past_count    = 0;
        checked_count = 0;
        back_to_back  = 1'b0;
        eighth        = angle_eighth(1);
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_op         <= OP_SIN;
        s_angle      <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_full_range();
        test_base_period();
        test_octant_edges();
        test_back_to_back();
        s_valid <= 1'b0;

        while (value_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
        if (value_q.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", value_q.size()));
        end

        $display("Sent %0d angles (%0d sine, %0d cosine, %0d past two pi), checked %0d results.",
                 sent_count, sin_count, cos_count, past_count, checked_count);
        $display("Covered octant edges, range extremes, random gaps and back-to-back flow.");
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* sin_cos_taylor_octant.f */
+incdir+src
src/sct_pkg.sv
src/sin_cos_taylor_octant.sv
src/sct_checker.sv
test/sin_cos_taylor_octant_tb.sv
